// ----- design/u16d_pkg.sv -----
package u16d_pkg;

  // Longest string index the decoder tracks; the unit index saturates below it.
  localparam int unsigned MAX_UNITS = 65536;
  localparam logic [15:0] INDEX_LIMIT =
    16'(((MAX_UNITS - 1) < 65535) ? (MAX_UNITS - 1) : 65535);

  // Counts saturate at the top of their 17-bit range.
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  // Surrogate detection masks and the supplementary-plane offset.
  localparam logic [15:0] SURR_MASK  = 16'hFC00;
  localparam logic [15:0] LEAD_BASE  = 16'hD800;
  localparam logic [15:0] TRAIL_BASE = 16'hDC00;
  localparam logic [20:0] PLANE_BASE = 21'h10000;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SWAP_IN   = 3'd0;
  localparam logic [2:0] CFG_SWAP_OUT  = 3'd1;
  localparam logic [2:0] CFG_ZERO_TERM = 3'd2;
  localparam logic [2:0] CFG_CAPACITY  = 3'd3;
  localparam logic [2:0] CFG_COUNT_REQ = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_BUSY     = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_NO_TRAIL = 3'd3;
  localparam logic [2:0] ST_NO_LEAD  = 3'd4;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } unit_item_t;

  typedef struct packed {
    logic [31:0] code_point;
    logic        emit;
    logic        finished;
    logic [2:0]  status;
    logic [16:0] result_count;
    logic [15:0] error_position;
  } point_item_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic        swap_output_bytes;
    logic        zero_terminated;
    logic [16:0] output_capacity;
    logic        count_required_size;
  } back_cfg_t;

  typedef enum logic [1:0] {
    CLS_PLAIN,
    CLS_LEAD,
    CLS_TRAIL
  } unit_class_t;

  // One classified unit as it travels from the front end to the back end.
  typedef struct packed {
    logic [15:0] unit;
    unit_class_t cls;
    logic        last;
  } cls_item_t;

endpackage

// ----- design/u16d_front.sv -----
module u16d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                swap_input_bytes,
  input  logic                unit_valid,
  output logic                unit_stall,
  input  u16d_pkg::unit_item_t unit_item,
  output logic                cls_valid,
  input  logic                cls_stall,
  output u16d_pkg::cls_item_t cls_item
);

  logic [15:0]           unit_fixed;
  u16d_pkg::unit_class_t cls_now;
  logic                  take;

  // Put the unit in natural byte order and sort it by surrogate range.
  always_comb begin
    unit_fixed = swap_input_bytes ? {unit_item.code_unit[7:0], unit_item.code_unit[15:8]}
                                  : unit_item.code_unit;
    if ((unit_fixed & u16d_pkg::SURR_MASK) == u16d_pkg::LEAD_BASE) begin
      cls_now = u16d_pkg::CLS_LEAD;
    end else if ((unit_fixed & u16d_pkg::SURR_MASK) == u16d_pkg::TRAIL_BASE) begin
      cls_now = u16d_pkg::CLS_TRAIL;
    end else begin
      cls_now = u16d_pkg::CLS_PLAIN;
    end
  end

  // The stage register refills whenever it is empty or drains this cycle.
  assign unit_stall = cls_valid && cls_stall;
  assign take       = unit_valid && !unit_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (!unit_stall) begin
      cls_valid <= unit_valid;
    end
    if (take) begin
      cls_item.unit <= unit_fixed;
      cls_item.cls  <= cls_now;
      cls_item.last <= unit_item.last_unit;
    end
  end

endmodule

// ----- design/u16d_queue.sv -----
module u16d_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_stall,
  input  u16d_pkg::cls_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_stall,
  output u16d_pkg::cls_item_t pop_item
);

  u16d_pkg::cls_item_t slots [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          fill;
  logic                push;
  logic                pop;

  assign push_stall = (fill == 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  // Two-entry ring between the classifier and the decoder.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- design/u16d_back.sv -----
module u16d_back (
  input  logic                 clk,
  input  logic                 rst,
  input  u16d_pkg::back_cfg_t  cfg,
  input  logic                 cls_valid,
  output logic                 cls_stall,
  input  u16d_pkg::cls_item_t  cls_item,
  output logic                 point_valid,
  input  logic                 point_stall,
  output u16d_pkg::point_item_t point_item
);

  // String state.
  logic [9:0]  pending_high;
  logic        pending_valid;
  logic [16:0] points_counted;
  logic [15:0] unit_index;
  logic        overflowed;

  logic [9:0]  pending_high_next;
  logic        pending_valid_next;
  logic [16:0] points_counted_next;
  logic [15:0] unit_index_next;
  logic        overflowed_next;

  logic        take;
  logic [20:0] point;
  logic        have_point;
  logic        ends;
  logic        emit;
  logic        finished;
  logic [2:0]  status;
  logic [16:0] count;
  logic [15:0] errpos;
  logic [31:0] point_out;
  logic [16:0] pc_inc;
  logic [16:0] cap_plus;

  assign cls_stall = point_valid && point_stall;
  assign take      = cls_valid && !cls_stall;

  assign pc_inc   = (points_counted < u16d_pkg::COUNT_MAX) ? points_counted + 17'd1
                                                           : points_counted;
  assign cap_plus = (cfg.output_capacity < u16d_pkg::COUNT_MAX)
                    ? cfg.output_capacity + 17'd1 : u16d_pkg::COUNT_MAX;

  // Decode one unit against the held surrogate and the output budget.
  always_comb begin
    pending_high_next   = pending_high;
    pending_valid_next  = pending_valid;
    points_counted_next = points_counted;
    overflowed_next     = overflowed;
    unit_index_next     = (unit_index < u16d_pkg::INDEX_LIMIT) ? unit_index + 16'd1
                                                               : unit_index;
    point      = {5'd0, cls_item.unit};
    have_point = 1'b0;
    ends       = 1'b0;
    emit       = 1'b0;
    finished   = 1'b0;
    status     = u16d_pkg::ST_BUSY;
    count      = 17'd0;
    errpos     = 16'd0;

    // Surrogate pairing.
    if (pending_valid) begin
      if (cls_item.cls == u16d_pkg::CLS_TRAIL) begin
        point              = {1'b0, pending_high, cls_item.unit[9:0]} + u16d_pkg::PLANE_BASE;
        pending_valid_next = 1'b0;
        have_point         = 1'b1;
      end else begin
        status = u16d_pkg::ST_NO_TRAIL;
        errpos = unit_index - 16'd1;
      end
    end else begin
      unique case (cls_item.cls)
        u16d_pkg::CLS_LEAD: begin
          if (!cfg.zero_terminated && cls_item.last) begin
            status = u16d_pkg::ST_NO_TRAIL;
            errpos = unit_index;
          end else begin
            pending_high_next  = cls_item.unit[9:0];
            pending_valid_next = 1'b1;
          end
        end
        u16d_pkg::CLS_TRAIL: begin
          status = u16d_pkg::ST_NO_LEAD;
          errpos = unit_index;
        end
        default: begin
          have_point = 1'b1;
        end
      endcase
    end

    // Budget, termination and overflow handling.
    if (status != u16d_pkg::ST_BUSY) begin
      finished = 1'b1;
    end else if (have_point) begin
      ends = cfg.zero_terminated ? (point == 21'd0) : cls_item.last;
      if (!overflowed && (points_counted < cfg.output_capacity)) begin
        emit = 1'b1;
      end else begin
        overflowed_next = 1'b1;
      end
      points_counted_next = pc_inc;
      if (ends) begin
        finished = 1'b1;
        status   = overflowed_next ? u16d_pkg::ST_OVERFLOW : u16d_pkg::ST_DONE;
        count    = pc_inc;
      end else if (emit && (pc_inc >= cfg.output_capacity) && !cfg.count_required_size) begin
        finished = 1'b1;
        status   = u16d_pkg::ST_OVERFLOW;
        count    = cap_plus;
      end
    end

    // A finished string leaves the state clear for the next one.
    if (finished) begin
      pending_high_next   = 10'd0;
      pending_valid_next  = 1'b0;
      points_counted_next = 17'd0;
      unit_index_next     = 16'd0;
      overflowed_next     = 1'b0;
    end

    if (!emit) begin
      point_out = 32'd0;
    end else if (cfg.swap_output_bytes) begin
      point_out = {point[7:0], point[15:8], 3'd0, point[20:16], 8'd0};
    end else begin
      point_out = {11'd0, point};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high   <= 10'd0;
      pending_valid  <= 1'b0;
      points_counted <= 17'd0;
      unit_index     <= 16'd0;
      overflowed     <= 1'b0;
      point_valid    <= 1'b0;
    end else begin
      if (!cls_stall) begin
        point_valid <= cls_valid;
      end
      if (take) begin
        pending_high   <= pending_high_next;
        pending_valid  <= pending_valid_next;
        points_counted <= points_counted_next;
        unit_index     <= unit_index_next;
        overflowed     <= overflowed_next;
      end
    end
    if (take) begin
      point_item.code_point     <= point_out;
      point_item.emit           <= emit;
      point_item.finished       <= finished;
      point_item.status         <= status;
      point_item.result_count   <= count;
      point_item.error_position <= errpos;
    end
  end

endmodule

// ----- design/utf16_to_utf32_stream_decoder.sv -----
// UTF-16 to UTF-32 stream decoder: one code unit goes in per item and exactly
// one result item comes out per unit, carrying the decoded code point (when it
// is written), the end-of-string flag, a status and the final count or error
// position. The block sustains one item per clock cycle while the sink does not
// stall; an item passes from acceptance through the classifier register, the
// two-entry queue and the decoder's output register to its result. Surrogate
// pairing and the capacity check are combinational in the decoder, so no input
// pattern slows it down. Configuration writes are registered and must only be
// made while no item is in flight. There is no clearing pass after reset.
module utf16_to_utf32_stream_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  unit_valid,
  output logic                  unit_stall,
  input  u16d_pkg::unit_item_t  unit_item,
  output logic                  point_valid,
  input  logic                  point_stall,
  output u16d_pkg::point_item_t point_item,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [16:0]           cfg_data
);

  logic                swap_input_bytes;
  u16d_pkg::back_cfg_t cfg;
  logic                cls_valid;
  logic                cls_stall;
  u16d_pkg::cls_item_t cls_item;
  logic                q_valid;
  logic                q_stall;
  u16d_pkg::cls_item_t q_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_input_bytes        <= 1'b0;
      cfg.swap_output_bytes   <= 1'b0;
      cfg.zero_terminated     <= 1'b1;
      cfg.output_capacity     <= 17'h10000;
      cfg.count_required_size <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        u16d_pkg::CFG_SWAP_IN:   swap_input_bytes        <= cfg_data[0];
        u16d_pkg::CFG_SWAP_OUT:  cfg.swap_output_bytes   <= cfg_data[0];
        u16d_pkg::CFG_ZERO_TERM: cfg.zero_terminated     <= cfg_data[0];
        u16d_pkg::CFG_CAPACITY:  cfg.output_capacity     <= cfg_data;
        u16d_pkg::CFG_COUNT_REQ: cfg.count_required_size <= cfg_data[0];
        default: ;
      endcase
    end
  end

  u16d_front u_front (
    .clk              (clk),
    .rst              (rst),
    .swap_input_bytes (swap_input_bytes),
    .unit_valid       (unit_valid),
    .unit_stall       (unit_stall),
    .unit_item        (unit_item),
    .cls_valid        (cls_valid),
    .cls_stall        (cls_stall),
    .cls_item         (cls_item)
  );

  u16d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cls_valid),
    .push_stall (cls_stall),
    .push_item  (cls_item),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_item   (q_item)
  );

  u16d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cls_valid   (q_valid),
    .cls_stall   (q_stall),
    .cls_item    (q_item),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point_item  (point_item)
  );

endmodule

// ----- design/u16d_checker.sv -----
module u16d_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  unit_valid,
  input logic                  unit_stall,
  input u16d_pkg::unit_item_t  unit_item,
  input logic                  point_valid,
  input logic                  point_stall,
  input u16d_pkg::point_item_t point_item
);

  // A stalled input item stays offered and unchanged.
  a_unit_hold: assert property (@(posedge clk) disable iff (rst)
    unit_valid && unit_stall |=> unit_valid && $stable(unit_item))
    else $error("input item changed while stalled");

  // A result waiting on a stalled sink stays offered and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_stall |=> point_valid && $stable(point_item))
    else $error("result item dropped or changed while stalled");

  // A code point that is not written reads as zero.
  a_quiet_point: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point_item.emit |-> point_item.code_point == 32'd0)
    else $error("code point set without emit");

  // Only a finished string reports a final status, and only then a count.
  a_status: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> (point_item.finished == (point_item.status != u16d_pkg::ST_BUSY)) &&
                    (point_item.finished || point_item.result_count == 17'd0))
    else $error("status does not agree with the finished flag");

  // An error never comes with an emitted code point.
  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    point_valid && (point_item.status == u16d_pkg::ST_NO_TRAIL ||
                    point_item.status == u16d_pkg::ST_NO_LEAD)
      |-> !point_item.emit && point_item.result_count == 17'd0)
    else $error("error item emits or counts");

endmodule

bind utf16_to_utf32_stream_decoder u16d_checker u_checker (.*);
